// ===== hdl/htcrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htcrc_pkg: shared types, constants and the CRC function of the sensor frame decoder
// Holds the CRC-8 step, the byte positions of the six-byte readout frame,
// the status codes and the constants of the fixed-point scaling.
// ----------------------------------------------------------------------------
package htcrc_pkg;

   // CRC-8 as used by the sensor: polynomial x^8 + x^5 + x^4 + 1, MSB first.
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_MSB  = 8'h80;

   // Position of a byte inside the readout frame.
   typedef logic [2:0] pos_type;
   localparam pos_type POS_TEMP_MSB = 3'd0;
   localparam pos_type POS_TEMP_LSB = 3'd1;
   localparam pos_type POS_TEMP_CRC = 3'd2;
   localparam pos_type POS_HUM_MSB  = 3'd3;
   localparam pos_type POS_HUM_LSB  = 3'd4;
   localparam pos_type POS_HUM_CRC  = 3'd5;

   // Result status; the temperature check takes priority.
   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_TEMP_CRC_ERR = 2'd1,
      STATUS_HUM_CRC_ERR  = 2'd2
   } status_type;

   // Scaling: value = floor(SPAN * raw / 65535), temperature offset by -45.00.
   localparam logic [30:0] TEMP_SPAN_CENTI   = 31'd17500;
   localparam logic [14:0] TEMP_OFFSET_CENTI = 15'd4500;
   localparam logic [29:0] HUM_SPAN_CENTI    = 30'd10000;
   localparam logic [13:0] HUM_MAX_CENTI     = 14'd10000;
   localparam logic [16:0] RAW_FULL_SCALE    = 17'd65535;

   // One byte of CRC-8 processing, eight bit steps.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/humidity_temp_frame_crc_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_crc_decoder_unit: CRC-checked sensor readout decoder
// Collects the six-byte frame (temperature word, CRC, humidity word, CRC),
// checks both words with CRC-8 and emits one scaled result per frame.
// ----------------------------------------------------------------------------
// Throughput: one byte word per clock cycle, sustained, on the request side;
// only a sixth byte waits, and only while an older result is not yet taken.
// The sixth frame byte passes the byte register and then the result register,
// where its result word becomes valid on the response side.
// Reset: synchronous, active high; clears both valid bits and returns the frame
// state to byte position zero with the CRC at 0xFF.

module humidity_temp_frame_crc_decoder_unit
   import htcrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request stream: one frame byte per word.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tuser,   // [0] frame_start
   // Response stream: one decoded result per complete frame.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [1:0] status, [16:2] temperature_centi,
                                    // [30:17] humidity_centi, [46:31] raw_temperature,
                                    // [62:47] raw_humidity, [63] zero
);

   // ------------------------------------------------------------------------
   // Byte register. It may load whenever it is empty or its byte moves on, so
   // the input keeps flowing; only a frame-closing byte has to wait for room
   // in the result register.
   // ------------------------------------------------------------------------
   logic       byte_valid_ff;
   logic [7:0] byte_data_ff;
   logic       byte_start_ff;

   logic       rsp_valid_ff;

   logic       rsp_ready;
   logic       byte_fire;
   logic       req_fire;

   assign rsp_ready = !rsp_valid_ff || rsp_tready;

   // ------------------------------------------------------------------------
   // Frame state and the per-byte decode.
   // ------------------------------------------------------------------------
   pos_type    pos_ff,   pos_in;
   logic [7:0] crc_ff,   crc_in;
   logic [15:0] temp_word_ff, temp_word_in;
   logic [15:0] hum_word_ff,  hum_word_in;
   logic        temp_good_ff, temp_good_in;

   logic       restart;
   pos_type    eff_pos;
   logic [7:0] crc_cur;
   logic [7:0] crc_step;
   logic       is_last;
   status_type frame_status;

   always_comb begin
      // A start flag, or a position that should never occur, begins a new frame.
      restart      = byte_start_ff || (pos_ff > POS_HUM_CRC);
      eff_pos      = restart ? POS_TEMP_MSB : pos_ff;
      crc_cur      = restart ? CRC_INIT : crc_ff;
      crc_step     = crc8_byte(crc_cur, byte_data_ff);
      is_last      = (eff_pos == POS_HUM_CRC);

      pos_in       = is_last ? POS_TEMP_MSB : eff_pos + 3'd1;
      crc_in       = crc_cur;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      temp_good_in = temp_good_ff;
      frame_status = STATUS_OK;

      unique case (eff_pos)
         POS_TEMP_MSB: begin
            temp_word_in = {byte_data_ff, temp_word_ff[7:0]};
            crc_in       = crc_step;
         end
         POS_TEMP_LSB: begin
            temp_word_in = {temp_word_ff[15:8], byte_data_ff};
            crc_in       = crc_step;
         end
         POS_TEMP_CRC: begin
            temp_good_in = (crc_cur == byte_data_ff);
            crc_in       = CRC_INIT;
         end
         POS_HUM_MSB: begin
            hum_word_in = {byte_data_ff, hum_word_ff[7:0]};
            crc_in      = crc_step;
         end
         POS_HUM_LSB: begin
            hum_word_in = {hum_word_ff[15:8], byte_data_ff};
            crc_in      = crc_step;
         end
         POS_HUM_CRC: begin
            crc_in = CRC_INIT;
            priority if (!temp_good_ff) begin
               frame_status = STATUS_TEMP_CRC_ERR;
            end else if (crc_cur != byte_data_ff) begin
               frame_status = STATUS_HUM_CRC_ERR;
            end else begin
               frame_status = STATUS_OK;
            end
         end
         default: begin
            crc_in = crc_cur;
         end
      endcase
   end

   // The byte leaves its register when it causes no result, or when the result
   // register can take the completed frame.
   assign byte_fire  = byte_valid_ff && (!is_last || rsp_ready);
   assign req_tready = !byte_valid_ff || byte_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req_tready) begin
         byte_valid_ff <= req_tvalid;
      end
      if (req_fire) begin
         byte_data_ff  <= req_tdata;
         byte_start_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_TEMP_MSB;
         crc_ff       <= CRC_INIT;
         temp_word_ff <= 16'h0000;
         hum_word_ff  <= 16'h0000;
         temp_good_ff <= 1'b0;
      end else if (byte_fire) begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_word_ff <= temp_word_in;
         hum_word_ff  <= hum_word_in;
         temp_good_ff <= temp_good_in;
      end
   end

   // ------------------------------------------------------------------------
   // Scaling. Both words are complete when the humidity CRC byte is decoded,
   // so the products come straight from the word registers. The spans are
   // constants, so each product is a handful of shifted adds.
   // Division by 65535: with x = 65536*q0 + lo, the remainder against 65535
   // is lo + q0, which stays below twice the divisor, so one compare fixes q.
   // ------------------------------------------------------------------------
   logic [30:0] temp_prod;
   logic [29:0] hum_prod;
   logic [14:0] temp_q0;
   logic [16:0] temp_r0;
   logic [14:0] temp_q;
   logic [14:0] temp_centi;
   logic [13:0] hum_q0;
   logic [16:0] hum_r0;
   logic [13:0] hum_q;
   logic [13:0] hum_centi;

   always_comb begin
      temp_prod  = TEMP_SPAN_CENTI * {15'd0, temp_word_ff};
      hum_prod   = HUM_SPAN_CENTI * {14'd0, hum_word_ff};

      temp_q0    = temp_prod[30:16];
      temp_r0    = {1'b0, temp_prod[15:0]} + {2'b00, temp_q0};
      temp_q     = temp_q0 + {14'd0, (temp_r0 >= RAW_FULL_SCALE)};
      temp_centi = temp_q - TEMP_OFFSET_CENTI;

      hum_q0     = hum_prod[29:16];
      hum_r0     = {1'b0, hum_prod[15:0]} + {3'b000, hum_q0};
      hum_q      = hum_q0 + {13'd0, (hum_r0 >= RAW_FULL_SCALE)};
      hum_centi  = (hum_q > HUM_MAX_CENTI) ? HUM_MAX_CENTI : hum_q;
   end

   // ------------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------------
   status_type         rsp_status_ff;
   logic signed [14:0] rsp_temp_centi_ff;
   logic [13:0]        rsp_hum_centi_ff;
   logic [15:0]        rsp_raw_temp_ff;
   logic [15:0]        rsp_raw_hum_ff;
   logic               rsp_load;

   assign rsp_load = byte_fire && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= rsp_load;
      end
      if (rsp_load) begin
         rsp_status_ff     <= frame_status;
         rsp_temp_centi_ff <= signed'(temp_centi);
         rsp_hum_centi_ff  <= hum_centi;
         rsp_raw_temp_ff   <= temp_word_ff;
         rsp_raw_hum_ff    <= hum_word_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_raw_hum_ff, rsp_raw_temp_ff, rsp_hum_centi_ff,
                        rsp_temp_centi_ff, rsp_status_ff};

`ifndef SYNTH
   // The frame position never leaves the six valid byte slots.
   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_HUM_CRC)
      else $error("frame position out of range");

   // A result appears only from the sixth byte of a frame.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(byte_fire && is_last))
      else $error("result register loaded without a completed frame");

   // A stalled result word stays put until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   // Scaled results stay inside their physical ranges.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hum_centi_ff <= HUM_MAX_CENTI) &&
                       (rsp_temp_centi_ff >= -15'sd4500) &&
                       (rsp_temp_centi_ff <= 15'sd13000))
      else $error("scaled result out of range");
`endif

endmodule
